### hw/rtl/assert_macros.svh
// Assertion helpers used by the scheduler checker (fps_checker).
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, quiet during reset.
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scheduler port check failed");

// Next-cycle implication, quiet during reset.
`define ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scheduler port check failed");

`endif

### hw/rtl/fps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fps_pkg
// Operation and status codes plus the control groups that pass between the
// scheduler sequencer and its queue blocks.
// ----------------------------------------------------------------------------
package fps_pkg;

  localparam int OP_W     = 3;
  localparam int STATUS_W = 3;

  localparam logic [OP_W-1:0] OP_CREATE    = 3'd0;
  localparam logic [OP_W-1:0] OP_TERMINATE = 3'd1;
  localparam logic [OP_W-1:0] OP_BLOCK     = 3'd2;
  localparam logic [OP_W-1:0] OP_WAKE      = 3'd3;
  localparam logic [OP_W-1:0] OP_QUERY     = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_BLOCKED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL        = 3'd2;
  localparam logic [STATUS_W-1:0] ST_IDS_OUT     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_IDLE_BLOCK  = 3'd4;

  // Ready queue requests.
  typedef struct packed {
    logic push;
    logic pop;
  } rdy_cmd_t;

  // Blocked list requests.
  typedef struct packed {
    logic push;
    logic search;
    logic remove;
  } blk_cmd_t;

  // Blocked list completion report.
  typedef struct packed {
    logic done;
    logic found;
  } blk_stat_t;

endpackage

### hw/rtl/fps_ready_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fps_ready_fifo
// Circular ready queue in a local memory; a pop returns the head in the next
// cycle through the registered read port.
// ----------------------------------------------------------------------------
module fps_ready_fifo #(
  parameter int DEPTH = 16,
  parameter int ID_W  = 16,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  fps_pkg::rdy_cmd_t     cmd,
  input  logic [ID_W-1:0]       wr_id,
  output logic [ID_W-1:0]       rd_id,
  output logic [CNT_W-1:0]      count
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

  logic [ID_W-1:0]  mem [DEPTH];
  logic [IDX_W-1:0] head;
  logic [IDX_W-1:0] tail;
  logic [CNT_W-1:0] count_r;

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[tail] <= wr_id;
    end
    if (cmd.pop) begin
      rd_id <= mem[head];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head    <= '0;
      tail    <= '0;
      count_r <= '0;
    end else begin
      if (cmd.push) begin
        tail <= (tail == LAST_IDX) ? '0 : tail + IDX_W'(1);
      end
      if (cmd.pop) begin
        head <= (head == LAST_IDX) ? '0 : head + IDX_W'(1);
      end
      case ({cmd.push, cmd.pop})
        2'b10:   count_r <= count_r + CNT_W'(1);
        2'b01:   count_r <= count_r - CNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  assign count = count_r;

endmodule

### hw/rtl/fps_blocked_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fps_blocked_list
// Order-keeping blocked list in a local memory. One comparator scans the
// entries a beat per cycle; removal compacts the tail down one slot at a time.
// ----------------------------------------------------------------------------
module fps_blocked_list #(
  parameter int DEPTH = 16,
  parameter int ID_W  = 16,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  fps_pkg::blk_cmd_t     cmd,
  input  logic [ID_W-1:0]       wr_id,
  input  logic [ID_W-1:0]       key,
  output fps_pkg::blk_stat_t    stat,
  output logic [CNT_W-1:0]      count
);

  localparam int IDX_W = $clog2(DEPTH);

  localparam logic [1:0] BS_IDLE  = 2'd0;
  localparam logic [1:0] BS_SCAN  = 2'd1;
  localparam logic [1:0] BS_SHIFT = 2'd2;

  logic [1:0]       state;
  logic [ID_W-1:0]  mem [DEPTH];
  logic [ID_W-1:0]  rd_data;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] rd_idx;
  logic [CNT_W-1:0] cmp_idx;
  logic [CNT_W-1:0] hit_idx;
  logic [CNT_W-1:0] wr_dst;
  logic             cmp_vld;
  logic             wr_pend;
  logic             done;
  logic             found;

  logic             rd_en;
  logic             match;
  logic             last;
  logic             we;
  logic [IDX_W-1:0] waddr;
  logic [ID_W-1:0]  wdata;
  logic             push_go;

  assign push_go = cmd.push && (state == BS_IDLE);
  assign rd_en   = ((state == BS_SCAN) || (state == BS_SHIFT)) && (rd_idx < count_r);
  assign match   = cmp_vld && (rd_data == key);
  assign last    = cmp_vld && (cmp_idx == count_r - CNT_W'(1));
  assign we      = push_go || ((state == BS_SHIFT) && wr_pend);
  assign waddr   = push_go ? count_r[IDX_W-1:0] : wr_dst[IDX_W-1:0];
  assign wdata   = push_go ? wr_id : rd_data;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rd_data <= mem[rd_idx[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= BS_IDLE;
      count_r <= '0;
      done    <= 1'b0;
      found   <= 1'b0;
      cmp_vld <= 1'b0;
      wr_pend <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        BS_IDLE: begin
          if (cmd.push) begin
            count_r <= count_r + CNT_W'(1);
          end else if (cmd.search) begin
            rd_idx  <= '0;
            cmp_vld <= 1'b0;
            if (count_r == '0) begin
              done  <= 1'b1;
              found <= 1'b0;
            end else begin
              state <= BS_SCAN;
            end
          end else if (cmd.remove) begin
            rd_idx  <= hit_idx + CNT_W'(1);
            wr_pend <= 1'b0;
            state   <= BS_SHIFT;
          end
        end
        BS_SCAN: begin
          // Oldest match wins: stop at the first hit.
          if (match) begin
            done    <= 1'b1;
            found   <= 1'b1;
            hit_idx <= cmp_idx;
            state   <= BS_IDLE;
          end else if (last) begin
            done  <= 1'b1;
            found <= 1'b0;
            state <= BS_IDLE;
          end else begin
            rd_idx  <= rd_idx + CNT_W'(1);
            cmp_idx <= rd_idx;
            cmp_vld <= 1'b1;
          end
        end
        BS_SHIFT: begin
          // Entry read this cycle lands one slot lower on the next.
          wr_pend <= rd_en;
          wr_dst  <= rd_idx - CNT_W'(1);
          if (rd_en) begin
            rd_idx <= rd_idx + CNT_W'(1);
          end else if (!wr_pend) begin
            done    <= 1'b1;
            count_r <= count_r - CNT_W'(1);
            state   <= BS_IDLE;
          end
        end
        default: begin
          state <= BS_IDLE;
        end
      endcase
    end
  end

  assign stat.done  = done;
  assign stat.found = found;
  assign count      = count_r;

endmodule

### hw/rtl/fifo_process_scheduler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_process_scheduler_top
// Process scheduler: one running process, a FIFO ready queue and an
// order-keeping blocked list, driven one operation at a time.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one operation beat: operation
//   and pid. Output channel (out_valid/out_ready) returns one result beat per
//   operation: status, new_pid, pid_is_running and the scheduler state after
//   the step (is_busy, running_pid, ready_level, blocked_level).
//   Sequence: create, query, unknown codes, refusals and steps that leave the
//   block idle pass through S_EXEC and S_DONE to out_valid; terminate and
//   block that dispatch from the ready queue add S_POP for the queue memory
//   read. Wakeup scans the n blocked entries one a cycle in S_SEARCH; a
//   miss, or a hit refused for a full ready queue, then goes to S_DONE, and
//   a hit first waits in S_REMOVE while compaction moves each later entry
//   down one slot. The single list memory port sets the worst case.
//   Handshake: in_ready is high only while the sequencer is idle, so the
//   next beat is accepted at the earliest while out_valid is first high.
//   Stall: a held result stays in the output register; a following result
//   waits in its final state until the register frees.
//   Reset clears the sequencer, counters and out_valid; the queue
//   memories are not cleared, since fill counts guard every read.
// ----------------------------------------------------------------------------
module fifo_process_scheduler_top #(
  parameter int QUEUE_DEPTH = 16,
  parameter int PID_WIDTH   = 16,
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [fps_pkg::OP_W-1:0]      operation,
  input  logic [PID_WIDTH-1:0]          pid,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [fps_pkg::STATUS_W-1:0]  status,
  output logic [PID_WIDTH-1:0]          new_pid,
  output logic                          pid_is_running,
  output logic                          is_busy,
  output logic [PID_WIDTH-1:0]          running_pid,
  output logic [CNT_W-1:0]              ready_level,
  output logic [CNT_W-1:0]              blocked_level
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_POP    = 3'd2;
  localparam logic [2:0] S_SEARCH = 3'd3;
  localparam logic [2:0] S_REMOVE = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  localparam logic [CNT_W-1:0] FULL_LEVEL = CNT_W'(QUEUE_DEPTH);

  // Sequencer and scheduler state.
  logic [2:0]                    state, state_next;
  logic [fps_pkg::OP_W-1:0]      op;
  logic [PID_WIDTH-1:0]          op_pid;
  logic [PID_WIDTH-1:0]          id_counter, id_counter_next;
  logic                          busy, busy_next;
  logic [PID_WIDTH-1:0]          running, running_next;
  logic [fps_pkg::STATUS_W-1:0]  result_status, result_status_next;
  logic [PID_WIDTH-1:0]          result_pid, result_pid_next;
  logic                          answer, answer_next;
  logic                          load_out;

  // Queue interfaces.
  fps_pkg::rdy_cmd_t             rdy_cmd;
  logic [PID_WIDTH-1:0]          rdy_wr_id;
  logic [PID_WIDTH-1:0]          rdy_rd_id;
  logic [CNT_W-1:0]              rdy_count;
  fps_pkg::blk_cmd_t             blk_cmd;
  fps_pkg::blk_stat_t            blk_stat;
  logic [CNT_W-1:0]              blk_count;

  logic                          accept;
  logic                          ready_full;
  logic                          blocked_full;
  logic                          ids_out;
  logic [PID_WIDTH-1:0]          id_plus;

  assign in_ready     = (state == S_IDLE);
  assign accept       = in_valid && in_ready;
  assign ready_full   = (rdy_count == FULL_LEVEL);
  assign blocked_full = (blk_count == FULL_LEVEL);
  assign ids_out      = &id_counter;
  assign id_plus      = id_counter + PID_WIDTH'(1);

  fps_ready_fifo #(
    .DEPTH (QUEUE_DEPTH),
    .ID_W  (PID_WIDTH)
  ) u_ready (
    .clk   (clk),
    .rst   (rst),
    .cmd   (rdy_cmd),
    .wr_id (rdy_wr_id),
    .rd_id (rdy_rd_id),
    .count (rdy_count)
  );

  fps_blocked_list #(
    .DEPTH (QUEUE_DEPTH),
    .ID_W  (PID_WIDTH)
  ) u_blocked (
    .clk   (clk),
    .rst   (rst),
    .cmd   (blk_cmd),
    .wr_id (running),
    .key   (op_pid),
    .stat  (blk_stat),
    .count (blk_count)
  );

  always_comb begin
    state_next         = state;
    id_counter_next    = id_counter;
    busy_next          = busy;
    running_next       = running;
    result_status_next = result_status;
    result_pid_next    = result_pid;
    answer_next        = answer;
    load_out           = 1'b0;
    rdy_cmd            = '0;
    rdy_wr_id          = running;
    blk_cmd            = '0;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          result_status_next = fps_pkg::ST_OK;
          result_pid_next    = '0;
          answer_next        = 1'b0;
          state_next         = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_DONE;
        unique case (op)
          fps_pkg::OP_CREATE: begin
            if (ids_out) begin
              result_status_next = fps_pkg::ST_IDS_OUT;
            end else if (busy && ready_full) begin
              result_status_next = fps_pkg::ST_FULL;
            end else begin
              id_counter_next = id_plus;
              result_pid_next = id_plus;
              if (busy) begin
                rdy_cmd.push = 1'b1;
                rdy_wr_id    = id_plus;
              end else begin
                running_next = id_plus;
                busy_next    = 1'b1;
              end
            end
          end
          fps_pkg::OP_TERMINATE, fps_pkg::OP_BLOCK: begin
            if (op == fps_pkg::OP_BLOCK && !busy) begin
              result_status_next = fps_pkg::ST_IDLE_BLOCK;
            end else if (op == fps_pkg::OP_BLOCK && blocked_full) begin
              result_status_next = fps_pkg::ST_FULL;
            end else if (busy) begin
              blk_cmd.push = (op == fps_pkg::OP_BLOCK);
              // Dispatch the ready head, or drop to idle.
              if (rdy_count != '0) begin
                rdy_cmd.pop = 1'b1;
                state_next  = S_POP;
              end else begin
                busy_next    = 1'b0;
                running_next = '0;
              end
            end
          end
          fps_pkg::OP_WAKE: begin
            blk_cmd.search = 1'b1;
            state_next     = S_SEARCH;
          end
          fps_pkg::OP_QUERY: begin
            answer_next = busy && (running == op_pid);
          end
          default: begin
            state_next = S_DONE;
          end
        endcase
      end
      S_POP: begin
        running_next = rdy_rd_id;
        busy_next    = 1'b1;
        state_next   = S_DONE;
      end
      S_SEARCH: begin
        if (blk_stat.done) begin
          if (!blk_stat.found) begin
            result_status_next = fps_pkg::ST_NOT_BLOCKED;
            state_next         = S_DONE;
          end else if (busy && ready_full) begin
            result_status_next = fps_pkg::ST_FULL;
            state_next         = S_DONE;
          end else begin
            // Preempt: current process to the ready tail, woken one runs.
            blk_cmd.remove = 1'b1;
            rdy_cmd.push   = busy;
            running_next   = op_pid;
            busy_next      = 1'b1;
            state_next     = S_REMOVE;
          end
        end
      end
      S_REMOVE: begin
        if (blk_stat.done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        // Hold here while the output register is still occupied.
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      id_counter <= '0;
      busy       <= 1'b0;
      running    <= '0;
    end else begin
      state      <= state_next;
      id_counter <= id_counter_next;
      busy       <= busy_next;
      running    <= running_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op     <= operation;
      op_pid <= pid;
    end
    result_status <= result_status_next;
    result_pid    <= result_pid_next;
    answer        <= answer_next;
  end

  // Output register: parts the sequencer from the receiver.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      status         <= result_status;
      new_pid        <= result_pid;
      pid_is_running <= answer;
      is_busy        <= busy;
      running_pid    <= busy ? running : '0;
      ready_level    <= rdy_count;
      blocked_level  <= blk_count;
    end
  end

endmodule

### hw/rtl/fps_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fps_checker
// Port-level checks on the scheduler, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fps_checker #(
  parameter int QUEUE_DEPTH = 16,
  parameter int PID_WIDTH   = 16,
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [fps_pkg::STATUS_W-1:0]  status,
  input logic [PID_WIDTH-1:0]          new_pid,
  input logic                          pid_is_running,
  input logic                          is_busy,
  input logic [PID_WIDTH-1:0]          running_pid,
  input logic [CNT_W-1:0]              ready_level,
  input logic [CNT_W-1:0]              blocked_level
);

  // A stalled result beat holds.
  `ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(running_pid))

  // One operation in flight: no back-to-back accept.
  `ASSERT_NXT(a_one_in_flight, in_valid && in_ready, !in_ready)

  // Levels never pass the queue depth.
  `ASSERT_IMP(a_levels, out_valid, ready_level <= CNT_W'(QUEUE_DEPTH) && blocked_level <= CNT_W'(QUEUE_DEPTH))

  // Idle shows no running id and no positive query answer.
  `ASSERT_IMP(a_idle_clean, out_valid && !is_busy, running_pid == '0 && !pid_is_running)

  // A refused operation hands out no id.
  `ASSERT_IMP(a_refused_no_id, out_valid && status != fps_pkg::ST_OK, new_pid == '0)

endmodule

bind fifo_process_scheduler_top fps_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH),
  .PID_WIDTH   (PID_WIDTH)
) u_fps_checker (.*);
